### rtl/bzr_pkg.sv
// Shared types, constants and helpers for the cubic Bezier easing pipeline.
// Depends on nothing; every other file in rtl/ imports it.
`default_nettype none
package bzr_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int GUARD       = 4;
    localparam int TBITS       = 30;
    localparam int VALUE_STEPS = 6;
    localparam int SLOPE_STEPS = 13;

    localparam int CW  = 18;             // control point and progress width
    localparam int PW  = 24;             // curve point width, FRAC_BITS + GUARD fraction bits
    localparam int TW  = TBITS + 1;      // curve parameter, unsigned Q30 up to 1.0
    localparam int DW  = PW + 1;         // span width
    localparam int NW  = 52;             // quotient numerator width, signed
    localparam int QW  = 29;             // quotient magnitude bits before overflow
    localparam int AW  = 24;             // answer width

    localparam logic [TW-1:0] ONE_T = TW'(1) << TBITS;
    localparam logic [TW-1:0] T_START = TW'(1) << (TBITS - 1);
    localparam logic [TW-1:0] R_VALUE = TW'(1) << (TBITS - 1 - VALUE_STEPS);
    localparam logic [TW-1:0] R_SLOPE = TW'(1) << (TBITS - 1 - SLOPE_STEPS);

    localparam logic signed [AW-1:0] ANS_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ANS_MIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE_Q   = CW'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        REG_CTRL1_X = 2'd0,
        REG_CTRL1_Y = 2'd1,
        REG_CTRL2_X = 2'd2,
        REG_CTRL2_Y = 2'd3
    } reg_idx_t;

    // One request on its way through the bisection stages.
    typedef struct packed {
        logic                 vld;
        logic                 cmd;
        logic                 clo;
        logic                 chi;
        logic signed [PW-1:0] pg;
        logic [TW-1:0]        t;
    } item_t;

    // One request inside the divider stages.
    typedef struct packed {
        logic                 vld;
        logic                 cmd;
        logic                 clo;
        logic                 chi;
        logic                 neg;
        logic                 ovf;
        logic                 dz;
        logic signed [PW-1:0] y1;
        logic [NW-1:0]        rem;
        logic [DW-1:0]        dmag;
        logic [QW-1:0]        q;
    } div_t;

endpackage
`default_nettype wire

### rtl/bzr_curve.sv
// Four-stage pipelined evaluation of one Bezier coordinate at parameter t.
// Depends on bzr_pkg.
`default_nettype none
module bzr_curve
    import bzr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [TW-1:0]        t,
    input  wire logic signed [CW-1:0] c1,
    input  wire logic signed [CW-1:0] c2,
    output logic signed [PW-1:0]      x
);

    logic [TW-1:0]         u;
    logic [2*TW-1:0]       uu_p, tt_p, m1_p, m2_p, b3_p;
    logic [TW-1:0]         t1_reg, u1_reg, uu_reg, tt_reg;
    logic [TW-1:0]         m1_reg, m2_reg, b3_reg, b3s_reg;
    logic [TW+1:0]         b1, b2;
    logic signed [51:0]    p1_next, p2_next, p1_reg, p2_reg;
    logic signed [53:0]    acc;
    logic signed [PW-1:0]  x_reg;

    assign u    = ONE_T - t;
    assign uu_p = u * u;
    assign tt_p = t * t;

    assign m1_p = uu_reg * t1_reg;
    assign m2_p = u1_reg * tt_reg;
    assign b3_p = tt_reg * t1_reg;

    // times three as shift and add
    assign b1 = {2'b00, m1_reg} + {1'b0, m1_reg, 1'b0};
    assign b2 = {2'b00, m2_reg} + {1'b0, m2_reg, 1'b0};
    assign p1_next = c1 * $signed({1'b0, b1});
    assign p2_next = c2 * $signed({1'b0, b2});

    assign acc = $signed({{2{p1_reg[51]}}, p1_reg}) + $signed({{2{p2_reg[51]}}, p2_reg})
               + $signed({{(54-TW-FRAC_BITS){1'b0}}, b3s_reg, {FRAC_BITS{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg  <= t;
            u1_reg  <= u;
            uu_reg  <= uu_p[TBITS +: TW];
            tt_reg  <= tt_p[TBITS +: TW];
            m1_reg  <= m1_p[TBITS +: TW];
            m2_reg  <= m2_p[TBITS +: TW];
            b3_reg  <= b3_p[TBITS +: TW];
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            b3s_reg <= b3_reg;
            x_reg   <= acc[TBITS-GUARD +: PW];
        end
    end

    assign x = x_reg;

endmodule
`default_nettype wire

### rtl/bzr_step.sv
// One bisection halving: a curve evaluation followed by the t update, 5 stages.
// Depends on bzr_pkg and bzr_curve.
`default_nettype none
module bzr_step
    import bzr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic [TW-1:0]        half,
    input  wire logic                 val_on,
    input  wire logic signed [CW-1:0] c1,
    input  wire logic signed [CW-1:0] c2,
    input  wire item_t                din,
    output item_t                     dout
);

    logic signed [PW-1:0] x;
    item_t                pipe_reg [4];
    item_t                out_next, out_reg;

    bzr_curve u_curve (
        .clk (clk),
        .en  (en),
        .t   (din.t),
        .c1  (c1),
        .c2  (c2),
        .x   (x)
    );

    // step toward the progress value; value requests stop after their own count
    always_comb
    begin
        out_next = pipe_reg[3];
        if (pipe_reg[3].cmd || val_on)
        begin
            if (x < pipe_reg[3].pg)
                out_next.t = pipe_reg[3].t + half;
            else
                out_next.t = pipe_reg[3].t - half;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                pipe_reg[i] <= '0;
            out_reg <= '0;
        end
        else if (en)
        begin
            pipe_reg[0] <= din;
            for (int i = 1; i < 4; i++)
                pipe_reg[i] <= pipe_reg[i-1];
            out_reg <= out_next;
        end
    end

    assign dout = out_reg;

endmodule
`default_nettype wire

### rtl/cubic_bezier_easing.sv
// Cubic Bezier easing evaluator, top level: config registers, bisection chain,
// bracket evaluation, span products and a restoring divider. Depends on
// bzr_pkg, bzr_step and bzr_curve.
//
// Usage:
//   s_* carries one request per beat: s_tuser[0] is the command (0 eased value,
//   1 slope dy/dx), s_tdata[17:0] the signed Q16 progress.
//   m_* returns one result per request, in order: m_tdata[23:0] the signed Q16
//   answer, m_tuser[0] set on a zero x span or a clipped answer, never on a clamp.
//   cfg_* writes the control points: index 0..3 = ctrl1_x, ctrl1_y, ctrl2_x,
//   ctrl2_y. Write only while no request is in flight. cfg_ready is always high.
// Throughput: one request per cycle unless the receiver stalls. The pipeline is
// 13 bisection steps of 5 stages and a 29-stage divider.
// Reset returns the control points to their defaults and empties the pipeline.
// When the receiver stalls, the whole pipeline holds and s_tready drops; no
// request is lost or repeated.
`default_nettype none
module cubic_bezier_easing
    import bzr_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [23:0]   s_tdata,   // [17:0] progress
    input  wire logic [0:0]    s_tuser,   // [0] cmd
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [23:0]        m_tdata,   // [23:0] answer
    output logic [0:0]         m_tuser,   // [0] saturated
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [17:0]   cfg_data
);

    logic signed [CW-1:0] c1x_reg, c1y_reg, c2x_reg, c2y_reg;
    logic                 en;

    // global advance: the pipeline moves unless the output holds an untaken result
    logic                 out_vld_reg;
    logic signed [AW-1:0] ans_reg;
    logic                 sat_reg;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1x_reg <= CW'(26214);
            c1y_reg <= CW'(0);
            c2x_reg <= CW'(13107);
            c2y_reg <= CW'(65536);
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CTRL1_X: c1x_reg <= cfg_data;
                REG_CTRL1_Y: c1y_reg <= cfg_data;
                REG_CTRL2_X: c2x_reg <= cfg_data;
                REG_CTRL2_Y: c2y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: classify the clamp cases and seed t at one half
    item_t                in_next, in_reg;
    logic signed [CW-1:0] prog;

    assign prog = s_tdata[CW-1:0];

    always_comb
    begin
        in_next.vld = s_tvalid;
        in_next.cmd = s_tuser[0];
        in_next.clo = !s_tuser[0] && (prog <= 0);
        in_next.chi = !s_tuser[0] && (prog >= ONE_Q);
        in_next.pg  = {{(PW-CW-GUARD){prog[CW-1]}}, prog, {GUARD{1'b0}}};
        in_next.t   = T_START;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_reg <= '0;
        else if (en)
            in_reg <= in_next;
    end

    // Bisection chain: one halving per step, slope requests use every step
    item_t chain [SLOPE_STEPS+1];
    assign chain[0] = in_reg;

    for (genvar k = 0; k < SLOPE_STEPS; k++)
    begin : g_step
        localparam logic [TW-1:0] HALF = TW'(1) << (TBITS - 2 - k);
        localparam logic          VAL_ON = (k < VALUE_STEPS);

        bzr_step u_step (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .half   (HALF),
            .val_on (VAL_ON),
            .c1     (c1x_reg),
            .c2     (c2x_reg),
            .din    (chain[k]),
            .dout   (chain[k+1])
        );
    end

    // Bracket: t - r and t + r, r being the last half step of the request
    item_t         br_item_reg;
    logic [TW-1:0] tm_reg, tp_reg, rr;

    assign rr = chain[SLOPE_STEPS].cmd ? R_SLOPE : R_VALUE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            br_item_reg <= '0;
        else if (en)
            br_item_reg <= chain[SLOPE_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tm_reg <= chain[SLOPE_STEPS].t - rr;
            tp_reg <= chain[SLOPE_STEPS].t + rr;
        end
    end

    logic signed [PW-1:0] x1, x2, y1, y2;

    bzr_curve u_x1 (.clk(clk), .en(en), .t(tm_reg), .c1(c1x_reg), .c2(c2x_reg), .x(x1));
    bzr_curve u_x2 (.clk(clk), .en(en), .t(tp_reg), .c1(c1x_reg), .c2(c2x_reg), .x(x2));
    bzr_curve u_y1 (.clk(clk), .en(en), .t(tm_reg), .c1(c1y_reg), .c2(c2y_reg), .x(y1));
    bzr_curve u_y2 (.clk(clk), .en(en), .t(tp_reg), .c1(c1y_reg), .c2(c2y_reg), .x(y2));

    item_t fp_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                fp_reg[i] <= '0;
        end
        else if (en)
        begin
            fp_reg[0] <= br_item_reg;
            for (int i = 1; i < 4; i++)
                fp_reg[i] <= fp_reg[i-1];
        end
    end

    // Spans
    item_t                d_item_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, a_reg;
    logic signed [PW-1:0] y1d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_item_reg <= '0;
        else if (en)
            d_item_reg <= fp_reg[3];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= {x2[PW-1], x2} - {x1[PW-1], x1};
            dy_reg  <= {y2[PW-1], y2} - {y1[PW-1], y1};
            a_reg   <= {fp_reg[3].pg[PW-1], fp_reg[3].pg} - {x1[PW-1], x1};
            y1d_reg <= y1;
        end
    end

    // Numerator: dy * (p - x1) for a value, dy scaled by one for a slope
    item_t                m_item_reg;
    logic signed [NW-1:0] n_next, n_reg;
    logic signed [DW-1:0] dxm_reg;
    logic signed [PW-1:0] y1m_reg;
    logic signed [2*DW-1:0] prod;

    assign prod = dy_reg * a_reg;

    always_comb
    begin
        if (d_item_reg.cmd)
            n_next = {{(NW-DW-FRAC_BITS){dy_reg[DW-1]}}, dy_reg, {FRAC_BITS{1'b0}}};
        else
            n_next = {{(NW-2*DW){prod[2*DW-1]}}, prod};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_item_reg <= '0;
        else if (en)
            m_item_reg <= d_item_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= n_next;
            dxm_reg <= dx_reg;
            y1m_reg <= y1d_reg;
        end
    end

    // Divider setup: magnitudes, signs, zero span and overflow detection
    div_t             div_reg [QW+1];
    div_t             div_in;
    logic [NW-1:0]    nmag;
    logic [DW-1:0]    dmag;
    logic             sn, sd, dz;

    assign sn   = n_reg[NW-1];
    assign sd   = dxm_reg[DW-1];
    assign nmag = sn ? NW'(-n_reg) : NW'(n_reg);
    assign dmag = sd ? DW'(-dxm_reg) : DW'(dxm_reg);
    assign dz   = (dxm_reg == '0);

    always_comb
    begin
        div_in.vld  = m_item_reg.vld;
        div_in.cmd  = m_item_reg.cmd;
        div_in.clo  = m_item_reg.clo;
        div_in.chi  = m_item_reg.chi;
        div_in.dz   = dz;
        div_in.neg  = dz ? sn : (sn ^ sd);
        div_in.ovf  = dz ? (n_reg != '0)
                         : ({{(DW+QW-NW){1'b0}}, nmag} >= {dmag, {QW{1'b0}}});
        div_in.y1   = y1m_reg;
        div_in.rem  = nmag;
        div_in.dmag = dmag;
        div_in.q    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_reg[0] <= '0;
        else if (en)
            div_reg[0] <= div_in;
    end

    // Restoring divider, one quotient bit per stage, most significant first
    for (genvar j = 0; j < QW; j++)
    begin : g_div
        localparam int K = QW - 1 - j;
        div_t                div_next;
        logic [DW+QW-1:0]    trial;
        logic                take;

        assign trial = {{QW{1'b0}}, div_reg[j].dmag} << K;
        assign take  = !div_reg[j].dz
                    && ({{(DW+QW-NW){1'b0}}, div_reg[j].rem} >= trial);

        always_comb
        begin
            div_next = div_reg[j];
            if (take)
            begin
                div_next.rem  = div_reg[j].rem - trial[NW-1:0];
                div_next.q[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_reg[j+1] <= '0;
            else if (en)
                div_reg[j+1] <= div_next;
        end
    end

    // Result: sign, offset by y1 and round for a value, then clamp or clip
    div_t                 fin;
    logic signed [QW:0]   qs;
    logic signed [QW+1:0] v;
    logic signed [QW:0]   sel;
    logic signed [AW-1:0] ans_next;
    logic                 sat_next;

    assign fin = div_reg[QW];
    assign qs  = fin.neg ? -$signed({1'b0, fin.q}) : $signed({1'b0, fin.q});
    assign v   = {qs[QW], qs} + {{(QW+2-PW){fin.y1[PW-1]}}, fin.y1}
               + (QW+2)'(1 << (GUARD - 1));

    always_comb
    begin
        if (fin.cmd)
            sel = qs;
        else
            sel = {{GUARD-1{v[QW+1]}}, v[QW+1:GUARD]};

        ans_next = sel[AW-1:0];
        sat_next = fin.dz;
        if (fin.clo)
        begin
            ans_next = '0;
            sat_next = 1'b0;
        end
        else if (fin.chi)
        begin
            ans_next = AW'(ONE_Q);
            sat_next = 1'b0;
        end
        else if (fin.ovf)
        begin
            ans_next = fin.neg ? ANS_MIN : ANS_MAX;
            sat_next = 1'b1;
        end
        else if (sel > $signed({{(QW+1-AW){ANS_MAX[AW-1]}}, ANS_MAX}))
        begin
            ans_next = ANS_MAX;
            sat_next = 1'b1;
        end
        else if (sel < $signed({{(QW+1-AW){ANS_MIN[AW-1]}}, ANS_MIN}))
        begin
            ans_next = ANS_MIN;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= fin.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ans_reg <= ans_next;
            sat_reg <= sat_next;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = ans_reg;
    assign m_tuser[0] = sat_reg;

endmodule
`default_nettype wire

### tb/cubic_bezier_easing_tb.sv
// Self-checking testbench for the cubic Bezier easing pipeline.
// Depends on bzr_pkg and cubic_bezier_easing; predicts each answer in
// fixed point and checks it against the stream output in order.
`default_nettype none
module cubic_bezier_easing_tb;
    import bzr_pkg::*;

    localparam int  LATENCY     = 104;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [23:0] answer;
        logic        saturated;
    } ease_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [17:0] cfg_data;

    // Predictor copy of the control points.
    longint pt1_x, pt1_y, pt2_x, pt2_y;

    ease_result_t pending_answers[$];
    int     mismatch_count;
    longint cycle_count;
    int     send_idle_pct;   // chance in percent of a gap before each request
    int     recv_idle_pct;   // chance in percent of a stall per cycle
    bit     recv_hold;       // long receiver hold-off, set by the pressure test
    int     hold_cycles;

    cubic_bezier_easing u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Bound the run; a hung pipeline fails here.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;   // arithmetic shift rounds toward minus infinity
    endfunction

    // One coordinate of the curve at parameter t (Q30); result in Q20.
    function automatic longint bezier_coord(longint c1, longint c2, longint t);
        longint one_t, u, uu, tt, b1, b2, b3;
        one_t = longint'(1) << TBITS;
        if (t > one_t)
            t = one_t;
        u  = one_t - t;
        uu = (u * u) >> TBITS;
        tt = (t * t) >> TBITS;
        b1 = 3 * ((uu * t) >> TBITS);
        b2 = 3 * ((u * tt) >> TBITS);
        b3 = (tt * t) >> TBITS;
        return floor_shr(c1 * b1 + c2 * b2 + b3 * (longint'(1) << FRAC_BITS),
                         TBITS - GUARD);
    endfunction

    function automatic longint clip_answer(longint v, ref bit flag);
        if (v > 8388607)
        begin
            flag = 1'b1;
            return 8388607;
        end
        if (v < -8388608)
        begin
            flag = 1'b1;
            return -8388608;
        end
        return v;
    endfunction

    function automatic ease_result_t predict_easing(bit slope, logic [17:0] prog_bits);
        ease_result_t res;
        longint p, one_q, pg, ans, t, r, x1, x2, y1, y2, dx, dy, num;
        int steps;
        bit flag;
        p     = longint'($signed(prog_bits));
        one_q = longint'(1) << FRAC_BITS;
        pg    = p * 16;
        flag  = 1'b0;
        t     = longint'(1) << (TBITS - 1);
        r     = t;
        steps = slope ? SLOPE_STEPS : VALUE_STEPS;
        if (!slope && p <= 0)
            ans = 0;
        else if (!slope && p >= one_q)
            ans = clip_answer(one_q, flag);
        else
        begin
            for (int i = 0; i < steps; i++)
            begin
                longint tx;
                tx = bezier_coord(pt1_x, pt2_x, t);
                r  = r >> 1;
                if (tx < pg)
                    t += r;
                else
                    t -= r;
            end
            x1 = bezier_coord(pt1_x, pt2_x, t - r);
            x2 = bezier_coord(pt1_x, pt2_x, t + r);
            y1 = bezier_coord(pt1_y, pt2_y, t - r);
            y2 = bezier_coord(pt1_y, pt2_y, t + r);
            dx = x2 - x1;
            dy = y2 - y1;
            if (!slope)
            begin
                num = dy * (pg - x1);
                if (dx == 0)
                begin
                    flag = 1'b1;
                    if (num > 0)
                        ans = 8388607;
                    else if (num < 0)
                        ans = -8388608;
                    else
                        ans = clip_answer(floor_shr(y1 + 8, GUARD), flag);
                end
                else
                    ans = clip_answer(floor_shr(num / dx + y1 + 8, GUARD), flag);
            end
            else if (dx == 0)
            begin
                flag = 1'b1;
                ans  = (dy > 0) ? 8388607 : (dy < 0) ? -8388608 : 0;
            end
            else
                ans = clip_answer((dy * one_q) / dx, flag);
        end
        res.answer    = ans[23:0];
        res.saturated = flag;
        return res;
    endfunction

    // Send one request and queue its expected answer once accepted.
    // Valid stays high after acceptance so requests can follow back to back.
    task automatic send_request(bit slope, logic [17:0] prog_bits);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= slope;
        s_tdata  <= {6'b0, prog_bits};
        do
            @(posedge clk);
        while (!s_tready);
        pending_answers.push_back(predict_easing(slope, prog_bits));
    endtask

    // Drain the pipeline, then write one control point.
    task automatic write_ctrl(reg_idx_t idx, logic [17:0] value);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CTRL1_X: pt1_x = longint'($signed(value));
            REG_CTRL1_Y: pt1_y = longint'($signed(value));
            REG_CTRL2_X: pt2_x = longint'($signed(value));
            default:     pt2_y = longint'($signed(value));
        endcase
    endtask

    task automatic set_curve(logic [17:0] ax, logic [17:0] ay,
                             logic [17:0] bx, logic [17:0] by);
        write_ctrl(REG_CTRL1_X, ax);
        write_ctrl(REG_CTRL1_Y, ay);
        write_ctrl(REG_CTRL2_X, bx);
        write_ctrl(REG_CTRL2_Y, by);
    endtask

    // Mostly the interesting range (0..1), sometimes anything.
    function automatic logic [17:0] random_progress();
        if ($urandom_range(3) == 0)
            return 18'($urandom);
        return 18'($urandom_range(65536));
    endfunction

    // Field extremes, both commands, clamp edges and zero progress.
    task automatic test_directed_edges();
        logic [17:0] edge_vals[8];
        edge_vals = '{18'h00000, 18'h00001, 18'h0FFFF, 18'h10000,
                      18'h1FFFF, 18'h20000, 18'h3FFFF, 18'h08000};
        foreach (edge_vals[i])
        begin
            send_request(1'b0, edge_vals[i]);
            send_request(1'b1, edge_vals[i]);
        end
    endtask

    // Random requests on the current curve.
    task automatic test_random_batch(int count);
        repeat (count)
            send_request(1'($urandom), random_progress());
    endtask

    // Flat and degenerate curves: zero x span and zero y span paths.
    task automatic test_degenerate_curves();
        set_curve(18'h00000, 18'h00000, 18'h00000, 18'h00000);
        test_directed_edges();
        set_curve(18'h00000, 18'h1FFFF, 18'h10000, 18'h20000);
        test_random_batch(40);
    endtask

    // Extreme control points, including a non-monotonic x.
    task automatic test_extreme_curves();
        set_curve(18'h1FFFF, 18'h1FFFF, 18'h20000, 18'h20000);
        test_random_batch(120);
        set_curve(18'h20000, 18'h20000, 18'h1FFFF, 18'h1FFFF);
        test_random_batch(120);
    endtask

    // Random control points: x in the usual range, y anything.
    task automatic test_random_curves();
        repeat (4)
        begin
            set_curve(18'($urandom_range(65536)), 18'($urandom),
                      18'($urandom_range(65536)), 18'($urandom));
            test_random_batch(60);
        end
    endtask

    // Hold the receiver off while requests keep coming, so the input stalls.
    task automatic test_backpressure();
        fork
            test_random_batch(150);
            begin
                recv_hold   = 1'b1;
                hold_cycles = 0;
                while (hold_cycles < 400)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                recv_hold = 1'b0;
            end
        join
    endtask

    // Receiver ready with random stalls.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare every accepted answer with the oldest expectation.
    initial
    begin
        ease_result_t exp_res;
        mismatch_count = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_answers.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected answer %h sat %b", m_tdata, m_tuser);
                end
                else
                begin
                    exp_res = pending_answers.pop_front();
                    if (m_tdata !== exp_res.answer || m_tuser[0] !== exp_res.saturated)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("answer exp %h/%b got %h/%b", exp_res.answer,
                                     exp_res.saturated, m_tdata, m_tuser);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CTRL1_X;
        cfg_data  = '0;
        recv_hold = 1'b0;
        pt1_x = 26214;
        pt1_y = 0;
        pt2_x = 13107;
        pt2_y = 65536;
        send_idle_pct = 22;
        recv_idle_pct = 22;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_batch(200);
        // Stretch with no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_batch(150);
        send_idle_pct = 22;
        recv_idle_pct = 22;
        test_backpressure();
        test_degenerate_curves();
        test_extreme_curves();
        test_random_curves();

        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
